// ----- src/wpf_pkg.sv -----
// Shared types, constants and the CRC-8 step for the wake packet framer.
`timescale 1ns / 1ps
package wpf_pkg;

	localparam int MAX_PAYLOAD = 128;
	localparam logic [7:0] CRC_POLY = 8'h8C;
	localparam logic [7:0] ADDR_FLAG = 8'h80;

	// Queue depths must be powers of two (pointers wrap naturally).
	localparam int JQ_DEPTH = 4;
	localparam int JQ_AW = $clog2(JQ_DEPTH);
	localparam int JQ_CW = $clog2(JQ_DEPTH + 1);
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW = $clog2(OQ_DEPTH);
	localparam int OQ_CW = $clog2(OQ_DEPTH + 1);

	localparam logic [7:0] RST_INITIAL_CRC = 8'd222;
	localparam logic [7:0] RST_FRAME_END = 8'd192;
	localparam logic [7:0] RST_ESCAPE = 8'd219;
	localparam logic [7:0] RST_ESC_END = 8'd220;
	localparam logic [7:0] RST_ESC_ESC = 8'd221;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_ADDR = 3'd1,
		ST_BAD_CMD  = 3'd2,
		ST_LEN_OVF  = 3'd3,
		ST_NO_FRAME = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		REG_INITIAL_CRC = 3'd0,
		REG_FRAME_END   = 3'd1,
		REG_ESCAPE      = 3'd2,
		REG_ESC_END     = 3'd3,
		REG_ESC_ESC     = 3'd4
	} reg_idx_t;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_DATA  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		JOB_STATUS = 2'd0,
		JOB_START  = 2'd1,
		JOB_DATA   = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		status_t     status;
		logic [7:0]  addr;
		logic [7:0]  pcmd;
		logic [7:0]  len;
		logic [7:0]  data;
		logic        close;
		logic [15:0] sent;
		logic [15:0] failed;
	} job_t;

	typedef struct packed {
		logic [7:0] init_crc;
		logic [7:0] fend;
		logic [7:0] fesc;
		logic [7:0] tfend;
		logic [7:0] tfesc;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  line_byte;
		logic        byte_valid;
		status_t     status;
		logic        last;
		logic        done;
		logic [15:0] sent;
		logic [15:0] failed;
	} out_item_t;

	function automatic logic [7:0] crc_update(input logic [7:0] crc_in, input logic [7:0] b_in);
		logic [7:0] c;
		logic [7:0] b;
		logic mix;
		c = crc_in;
		b = b_in;
		for (int k = 0; k < 8; k++) begin
			mix = c[0] ^ b[0];
			c = c >> 1;
			if (mix) begin
				c = c ^ CRC_POLY;
			end
			b = b >> 1;
		end
		return c;
	endfunction

endpackage

// ----- src/wpf_front.sv -----
// Front end: accepts items, checks headers, tracks frame state, queues jobs.
`timescale 1ns / 1ps
module wpf_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic          command,
	input  logic [7:0]    address,
	input  logic [7:0]    packet_command,
	input  logic [7:0]    length,
	input  logic [7:0]    data_byte,
	output wpf_pkg::job_t job_head,
	output logic          job_valid,
	input  logic          job_pop
);
	import wpf_pkg::*;

	job_t             jq_mem [JQ_DEPTH];
	logic [JQ_AW-1:0] wr_ptr_q;
	logic [JQ_AW-1:0] rd_ptr_q;
	logic [JQ_CW-1:0] cnt_q;

	logic        open_q;
	logic [7:0]  remain_q;
	logic [15:0] sent_q;
	logic [15:0] failed_q;

	logic        open_n;
	logic [7:0]  remain_n;
	logic [15:0] sent_n;
	logic [15:0] failed_n;
	status_t     err;
	job_t        job_new;
	logic        accept;

	assign full = (cnt_q == JQ_CW'(JQ_DEPTH));
	assign accept = push && !full;
	assign job_valid = (cnt_q != '0);
	assign job_head = jq_mem[rd_ptr_q];

	always_comb begin
		open_n = open_q;
		remain_n = remain_q;
		sent_n = sent_q;
		failed_n = failed_q;
		err = ST_OK;
		job_new = '0;
		job_new.kind = JOB_STATUS;
		job_new.status = ST_OK;
		job_new.addr = address;
		job_new.pcmd = packet_command;
		job_new.len = length;
		job_new.data = data_byte;
		if (cmd_t'(command) == CMD_START) begin
			sent_n = sent_q + 16'd1;
			open_n = 1'b0;
			remain_n = 8'd0;
			if (address[7] || address == 8'd0) begin
				err = ST_BAD_ADDR;
			end else if (packet_command[7]) begin
				err = ST_BAD_CMD;
			end else if (length > 8'(MAX_PAYLOAD)) begin
				err = ST_LEN_OVF;
			end
			if (err != ST_OK) begin
				failed_n = failed_q + 16'd1;
				job_new.status = err;
			end else begin
				job_new.kind = JOB_START;
				job_new.close = (length == 8'd0);
				open_n = (length != 8'd0);
				remain_n = length;
			end
		end else if (!open_q) begin
			job_new.status = ST_NO_FRAME;
		end else begin
			job_new.kind = JOB_DATA;
			job_new.close = (remain_q == 8'd1);
			open_n = (remain_q != 8'd1);
			remain_n = remain_q - 8'd1;
		end
		job_new.sent = sent_n;
		job_new.failed = failed_n;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			jq_mem[wr_ptr_q] <= job_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
			open_q <= 1'b0;
			remain_q <= 8'd0;
			sent_q <= 16'd0;
			failed_q <= 16'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + JQ_AW'(1);
				open_q <= open_n;
				remain_q <= remain_n;
				sent_q <= sent_n;
				failed_q <= failed_n;
			end
			if (job_pop) begin
				rd_ptr_q <= rd_ptr_q + JQ_AW'(1);
			end
			case ({accept, job_pop})
				2'b10: cnt_q <= cnt_q + JQ_CW'(1);
				2'b01: cnt_q <= cnt_q - JQ_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- src/wpf_back.sv -----
// Back end: expands jobs into stuffed line bytes with CRC, feeds the result queue.
`timescale 1ns / 1ps
module wpf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  wpf_pkg::cfg_t      cfg,
	input  wpf_pkg::job_t      job,
	input  logic               job_valid,
	output logic               job_pop,
	output wpf_pkg::out_item_t out_head,
	output logic               empty,
	input  logic               pop
);
	import wpf_pkg::*;

	localparam logic [2:0] STEP_FEND = 3'd0;
	localparam logic [2:0] STEP_ADDR = 3'd1;
	localparam logic [2:0] STEP_CMD  = 3'd2;
	localparam logic [2:0] STEP_LEN  = 3'd3;
	localparam logic [2:0] STEP_HCRC = 3'd4;
	localparam logic [2:0] STEP_DATA = 3'd0;
	localparam logic [2:0] STEP_DCRC = 3'd1;

	logic [2:0] step_q;
	logic       esc_q;
	logic       esc_end_q;
	logic [7:0] crc_q;

	out_item_t        oq_mem [OQ_DEPTH];
	logic [OQ_AW-1:0] owr_ptr_q;
	logic [OQ_AW-1:0] ord_ptr_q;
	logic [OQ_CW-1:0] ocnt_q;
	logic             oq_full;
	logic             opop;

	logic [7:0] sym;
	logic [7:0] crc_in;
	logic [7:0] crc_base;
	logic       stuff;
	logic       covered;
	logic       is_crc;
	logic       last_sym;
	logic       hit_end;
	logic       hit_esc;
	logic       sym_done;
	logic       advance;
	out_item_t  item;

	assign oq_full = (ocnt_q == OQ_CW'(OQ_DEPTH));
	assign empty = (ocnt_q == '0);
	assign opop = pop && !empty;
	assign out_head = oq_mem[ord_ptr_q];
	assign advance = job_valid && !oq_full;

	always_comb begin
		sym = 8'd0;
		crc_in = 8'd0;
		stuff = 1'b0;
		covered = 1'b0;
		is_crc = 1'b0;
		last_sym = 1'b1;
		crc_base = crc_q;
		unique case (job.kind)
			JOB_START: begin
				last_sym = job.close ? (step_q == STEP_HCRC) : (step_q == STEP_LEN);
				if (step_q == STEP_FEND) begin
					crc_base = cfg.init_crc;
				end
				case (step_q)
					STEP_FEND: begin
						sym = cfg.fend;
						crc_in = cfg.fend;
						covered = 1'b1;
					end
					STEP_ADDR: begin
						sym = job.addr | ADDR_FLAG;
						crc_in = job.addr;
						covered = 1'b1;
						stuff = 1'b1;
					end
					STEP_CMD: begin
						sym = job.pcmd;
						crc_in = job.pcmd;
						covered = 1'b1;
					end
					STEP_LEN: begin
						sym = job.len;
						crc_in = job.len;
						covered = 1'b1;
						stuff = 1'b1;
					end
					default: begin
						sym = crc_q;
						stuff = 1'b1;
						is_crc = 1'b1;
					end
				endcase
			end
			JOB_DATA: begin
				last_sym = job.close ? (step_q == STEP_DCRC) : (step_q == STEP_DATA);
				if (step_q == STEP_DATA) begin
					sym = job.data;
					crc_in = job.data;
					covered = 1'b1;
					stuff = 1'b1;
				end else begin
					sym = crc_q;
					stuff = 1'b1;
					is_crc = 1'b1;
				end
			end
			default: begin
			end
		endcase

		hit_end = stuff && (sym == cfg.fend);
		hit_esc = stuff && (sym == cfg.fesc);

		item = '0;
		item.status = ST_OK;
		sym_done = 1'b1;
		if (esc_q) begin
			item.line_byte = esc_end_q ? cfg.tfend : cfg.tfesc;
		end else if (hit_end || hit_esc) begin
			item.line_byte = cfg.fesc;
			sym_done = 1'b0;
		end else begin
			item.line_byte = sym;
		end
		item.byte_valid = (job.kind != JOB_STATUS);
		item.status = (job.kind == JOB_STATUS) ? job.status : ST_OK;
		item.last = sym_done && last_sym;
		item.done = sym_done && is_crc;
		item.sent = job.sent;
		item.failed = job.failed;

		job_pop = advance && sym_done && last_sym;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			oq_mem[owr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_FEND;
			esc_q <= 1'b0;
			esc_end_q <= 1'b0;
			crc_q <= 8'd0;
			owr_ptr_q <= '0;
			ord_ptr_q <= '0;
			ocnt_q <= '0;
		end else begin
			if (advance) begin
				owr_ptr_q <= owr_ptr_q + OQ_AW'(1);
				if (sym_done) begin
					esc_q <= 1'b0;
					step_q <= last_sym ? STEP_FEND : step_q + 3'd1;
					if (covered) begin
						crc_q <= crc_update(crc_base, crc_in);
					end
				end else begin
					esc_q <= 1'b1;
					esc_end_q <= hit_end;
				end
			end
			if (opop) begin
				ord_ptr_q <= ord_ptr_q + OQ_AW'(1);
			end
			case ({advance, opop})
				2'b10: ocnt_q <= ocnt_q + OQ_CW'(1);
				2'b01: ocnt_q <= ocnt_q - OQ_CW'(1);
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) ocnt_q <= OQ_CW'(OQ_DEPTH))
		else $error("result queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n) esc_q |-> job_valid)
		else $error("escape pending with no job");

	assert property (@(posedge clk) disable iff (!arst_n) advance && item.done |-> item.last)
		else $error("frame end not on last byte of run");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (job.kind == JOB_STATUS) |-> job_pop && !item.byte_valid)
		else $error("status job must take exactly one transaction");

endmodule

// ----- src/wake_packet_framer_top.sv -----
// Top level of the wake packet framer: config registers, front and back ends.
//
// channel  | handshake           | payload
// ---------+---------------------+---------------------------------------------
// input    | push / full         | command, address, packet_command, length,
//          |                     | data_byte
// result   | empty / pop         | line_byte, byte_valid, status, last_of_run,
//          |                     | frame_done, sent_count, failed_count
// config   | cfg_we              | cfg_index, cfg_data
//
// The front end takes one input transaction per clock while its 4-entry job
// queue has room. The back end sequencer emits one line byte per clock into a
// 4-entry result queue while a job waits and that queue has room; a rejected
// item gives a single status entry with no line byte. Reset clears all
// control state and loads the register defaults; no clearing pass. With pop
// held low the result queue fills, then the job queue, then full.
`timescale 1ns / 1ps
module wake_packet_framer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        command,
	input  logic [7:0]  address,
	input  logic [7:0]  packet_command,
	input  logic [7:0]  length,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  line_byte,
	output logic        byte_valid,
	output logic [2:0]  status,
	output logic        last_of_run,
	output logic        frame_done,
	output logic [15:0] sent_count,
	output logic [15:0] failed_count,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import wpf_pkg::*;

	cfg_t      cfg_q;
	job_t      job_head;
	logic      job_valid;
	logic      job_pop;
	out_item_t out_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.init_crc <= RST_INITIAL_CRC;
			cfg_q.fend <= RST_FRAME_END;
			cfg_q.fesc <= RST_ESCAPE;
			cfg_q.tfend <= RST_ESC_END;
			cfg_q.tfesc <= RST_ESC_ESC;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_INITIAL_CRC: cfg_q.init_crc <= cfg_data;
				REG_FRAME_END: cfg_q.fend <= cfg_data;
				REG_ESCAPE: cfg_q.fesc <= cfg_data;
				REG_ESC_END: cfg_q.tfend <= cfg_data;
				REG_ESC_ESC: cfg_q.tfesc <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	wpf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.command        (command),
		.address        (address),
		.packet_command (packet_command),
		.length         (length),
		.data_byte      (data_byte),
		.job_head       (job_head),
		.job_valid      (job_valid),
		.job_pop        (job_pop)
	);

	wpf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job       (job_head),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.out_head  (out_head),
		.empty     (empty),
		.pop       (pop)
	);

	assign line_byte = out_head.line_byte;
	assign byte_valid = out_head.byte_valid;
	assign status = out_head.status;
	assign last_of_run = out_head.last;
	assign frame_done = out_head.done;
	assign sent_count = out_head.sent;
	assign failed_count = out_head.failed;

endmodule
